[sv/sdlp_pkg.sv]
package sdlp_pkg;

  localparam int NUM_SW = 4;
  localparam int TICK_W = 8;
  localparam logic [TICK_W-1:0] LONG_PRESS_RESET = TICK_W'(100);

  // Per-switch status after one tick
  typedef struct packed {
    logic pressed;
    logic changed;
    logic fire;
    logic mark;
  } lane_out_t;

endpackage

[sv/switch_debounce_long_press_core.sv]
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | in_raw_levels
// out     | output    | out_valid/out_stall| out_pressed, out_changed, out_long_event,
//         |           |                    | out_long_held, out_led_on
// cfg     | input     | cfg_valid/cfg_ready| cfg_data (long-press length in ticks)
//
// One tick per cycle sustained while out_stall is low; a tick's result passes through the input
// register, then the per-switch update into the result register.
// Synchronous active-low reset clears all switch state and the LED, and loads
// a long-press length of 100 ticks.
// A stalled result holds the result register; one more tick waits in the input
// register, after which in_stall rises. cfg_ready is always high.
module switch_debounce_long_press_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sdlp_pkg::NUM_SW-1:0]  in_raw_levels,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sdlp_pkg::NUM_SW-1:0]  out_pressed,
  output logic [sdlp_pkg::NUM_SW-1:0]  out_changed,
  output logic [sdlp_pkg::NUM_SW-1:0]  out_long_event,
  output logic [sdlp_pkg::NUM_SW-1:0]  out_long_held,
  output logic                         out_led_on,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sdlp_pkg::TICK_W-1:0]  cfg_data
);
  import sdlp_pkg::*;

  logic [TICK_W-1:0] long_ticks_r;
  logic              a_valid_r;
  logic [NUM_SW-1:0] a_raw_r;
  logic              o_valid_r;
  logic [NUM_SW-1:0] o_pressed_r, o_changed_r, o_event_r, o_held_r;
  logic              led_r, led_nxt;
  logic              o_load;
  logic              step;
  logic [NUM_SW-1:0] pr, ch, ev, held;
  lane_out_t         lane_st [NUM_SW];

  assign cfg_ready = 1'b1;

  // result register frees when empty or taken this cycle
  assign o_load   = !o_valid_r || !out_stall;
  assign step     = a_valid_r && o_load;
  assign in_stall = a_valid_r && !o_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_ticks_r <= LONG_PRESS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      long_ticks_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (!in_stall) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_raw_r <= in_raw_levels;
    end
  end

  for (genvar i = 0; i < NUM_SW; i++) begin : g_lane
    sdlp_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .step       (step),
      .raw_level  (a_raw_r[i]),
      .long_ticks (long_ticks_r),
      .status     (lane_st[i])
    );
    assign pr[i]   = lane_st[i].pressed;
    assign ch[i]   = lane_st[i].changed;
    assign ev[i]   = lane_st[i].fire;
    assign held[i] = lane_st[i].mark;
  end

  // both switches firing together toggle twice: no change
  always_comb begin
    led_nxt = led_r;
    if (held[0] && held[1]) begin
      led_nxt = led_r ^ ev[0] ^ ev[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
      led_r     <= 1'b0;
    end else if (o_load) begin
      o_valid_r <= a_valid_r;
      if (a_valid_r) begin
        led_r <= led_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      o_pressed_r <= pr;
      o_changed_r <= ch;
      o_event_r   <= ev;
      o_held_r    <= held;
    end
  end

  assign out_valid      = o_valid_r;
  assign out_pressed    = o_pressed_r;
  assign out_changed    = o_changed_r;
  assign out_long_event = o_event_r;
  assign out_long_held  = o_held_r;
  assign out_led_on     = led_r;

endmodule

[sv/sdlp_lane.sv]
module sdlp_lane (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic                       raw_level,
  input  logic [sdlp_pkg::TICK_W-1:0] long_ticks,
  output sdlp_pkg::lane_out_t        status
);
  import sdlp_pkg::*;

  logic              last_r, last_nxt;
  logic              settled_r, settled_nxt;
  logic [TICK_W-1:0] cnt_r, cnt_nxt;
  logic              mark_r, mark_nxt;
  logic              chg;
  logic              fire;
  logic              down;

  always_comb begin
    down        = ~raw_level;
    last_nxt    = down;
    settled_nxt = settled_r;
    chg         = 1'b0;
    fire        = 1'b0;
    cnt_nxt     = cnt_r;
    mark_nxt    = mark_r;

    // move only when this sample matches the previous one and differs from settled
    if (down == last_r && down != settled_r) begin
      settled_nxt = down;
      chg         = 1'b1;
    end

    if (chg && settled_nxt) begin
      cnt_nxt  = long_ticks;
      mark_nxt = 1'b0;
    end

    if (settled_nxt) begin
      if (!mark_nxt && cnt_nxt != '0) begin
        cnt_nxt = cnt_nxt - TICK_W'(1);
        if (cnt_nxt == '0) begin
          mark_nxt = 1'b1;
          fire     = 1'b1;
        end
      end
    end else begin
      cnt_nxt  = '0;
      mark_nxt = 1'b0;
    end

    status.pressed = settled_nxt;
    status.changed = chg;
    status.fire    = fire;
    status.mark    = mark_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r    <= 1'b0;
      settled_r <= 1'b0;
      cnt_r     <= '0;
      mark_r    <= 1'b0;
    end else if (step) begin
      last_r    <= last_nxt;
      settled_r <= settled_nxt;
      cnt_r     <= cnt_nxt;
      mark_r    <= mark_nxt;
    end
  end

endmodule

[tb/tb_switch_debounce_long_press_core.sv]
module tb_switch_debounce_long_press_core;
  import sdlp_pkg::*;

  typedef struct packed {
    logic [NUM_SW-1:0] pressed;
    logic [NUM_SW-1:0] changed;
    logic [NUM_SW-1:0] long_event;
    logic [NUM_SW-1:0] long_held;
    logic              led_on;
  } tick_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [NUM_SW-1:0] in_raw_levels = '1;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [NUM_SW-1:0] out_pressed;
  logic [NUM_SW-1:0] out_changed;
  logic [NUM_SW-1:0] out_long_event;
  logic [NUM_SW-1:0] out_long_held;
  logic              out_led_on;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [TICK_W-1:0] cfg_data = '0;

  // Predicted switch state
  logic [NUM_SW-1:0] sample_q;
  logic [NUM_SW-1:0] settled_q;
  logic [TICK_W-1:0] hold_cnt [NUM_SW];
  logic [NUM_SW-1:0] held_mark;
  logic              led_q;
  logic [TICK_W-1:0] press_len;

  tick_result_t pending_ticks [$];
  int           errors = 0;
  bit           quiet = 1'b0;
  int           stall_left = 0;

  switch_debounce_long_press_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_raw_levels  (in_raw_levels),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pressed    (out_pressed),
    .out_changed    (out_changed),
    .out_long_event (out_long_event),
    .out_long_held  (out_long_held),
    .out_led_on     (out_led_on),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic tick_result_t debounce_tick(input logic [NUM_SW-1:0] raw);
    tick_result_t r;
    bit           down;
    bit           chg;
    bit           fire;
    r = '0;
    for (int i = 0; i < NUM_SW; i++) begin
      down = !raw[i];
      chg  = 1'b0;
      fire = 1'b0;
      // settle only on two equal samples in a row
      if (down) begin
        if (!sample_q[i]) sample_q[i] = 1'b1;
        else if (!settled_q[i]) begin
          settled_q[i] = 1'b1;
          chg = 1'b1;
        end
      end else begin
        if (sample_q[i]) sample_q[i] = 1'b0;
        else if (settled_q[i]) begin
          settled_q[i] = 1'b0;
          chg = 1'b1;
        end
      end
      if (chg && settled_q[i]) begin
        hold_cnt[i]  = press_len;
        held_mark[i] = 1'b0;
      end
      if (settled_q[i]) begin
        // count down from the press tick itself
        if (!held_mark[i] && hold_cnt[i] != '0) begin
          hold_cnt[i] = hold_cnt[i] - 1'b1;
          if (hold_cnt[i] == '0) begin
            held_mark[i] = 1'b1;
            fire = 1'b1;
          end
        end
      end else begin
        hold_cnt[i]  = '0;
        held_mark[i] = 1'b0;
      end
      r.pressed[i]    = settled_q[i];
      r.changed[i]    = chg;
      r.long_event[i] = fire;
      r.long_held[i]  = held_mark[i];
    end
    // both switches firing together toggle twice
    if (held_mark[0] && held_mark[1]) begin
      if (r.long_event[0]) led_q = ~led_q;
      if (r.long_event[1]) led_q = ~led_q;
    end
    r.led_on = led_q;
    return r;
  endfunction

  function automatic void check_field(string name, logic [NUM_SW-1:0] want,
                                      logic [NUM_SW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= ($urandom_range(0, 2) == 0);
      stall_left <= $urandom_range(0, 6);
    end
  end

  always @(posedge clk) begin
    tick_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_ticks.size() == 0) begin
        $error("result transfer with no tick pending");
        errors++;
      end else begin
        want = pending_ticks.pop_front();
        check_field("pressed", want.pressed, out_pressed);
        check_field("changed", want.changed, out_changed);
        check_field("long_event", want.long_event, out_long_event);
        check_field("long_held", want.long_held, out_long_held);
        check_field("led_on", NUM_SW'(want.led_on), NUM_SW'(out_led_on));
      end
    end
  end

  task automatic send_tick(input logic [NUM_SW-1:0] raw);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_raw_levels <= raw;
    do @(posedge clk); while (in_stall);
    pending_ticks.push_back(debounce_tick(raw));
  endtask

  task automatic hold_levels(input logic [NUM_SW-1:0] raw, input int n);
    repeat (n) send_tick(raw);
  endtask

  task automatic wait_all_ticks();
    in_valid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
    // cover the two-stage pipeline
    repeat (4) @(posedge clk);
  endtask

  task automatic set_press_length(input logic [TICK_W-1:0] len);
    wait_all_ticks();
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    press_len = len;
  endtask

  task automatic test_reset_length();
    hold_levels(4'h7, 103);
    hold_levels(4'hF, 2);
  endtask

  task automatic test_single_tick_length();
    set_press_length(TICK_W'(1));
    send_tick(4'hF);
    hold_levels(4'h0, 3);
    hold_levels(4'hF, 2);
    send_tick(4'h5);
    send_tick(4'hA);
    hold_levels(4'h5, 2);
    hold_levels(4'hF, 2);
  endtask

  task automatic test_led_toggle();
    set_press_length(TICK_W'(2));
    hold_levels(4'hE, 4);
    // switch 1 fires while switch 0 is long held
    hold_levels(4'hC, 4);
    hold_levels(4'hD, 2);
    // switch 0 fires while switch 1 is long held
    hold_levels(4'hC, 4);
    hold_levels(4'hF, 2);
    // both fire on the same tick: no net toggle
    hold_levels(4'hC, 4);
    hold_levels(4'hF, 2);
  endtask

  task automatic test_zero_length();
    set_press_length('0);
    hold_levels(4'h0, 5);
    hold_levels(4'hF, 2);
  endtask

  task automatic test_max_length();
    set_press_length('1);
    hold_levels(4'hB, 258);
    hold_levels(4'hF, 2);
  endtask

  task automatic test_random_presses(input logic [TICK_W-1:0] len, input int items);
    logic [NUM_SW-1:0] target;
    logic [NUM_SW-1:0] raw;
    int                run_left [NUM_SW];
    set_press_length(len);
    target = '1;
    for (int i = 0; i < NUM_SW; i++) run_left[i] = $urandom_range(0, 4);
    repeat (items) begin
      for (int i = 0; i < NUM_SW; i++) begin
        if (run_left[i] == 0) begin
          target[i] = ~target[i];
          // mostly holds long enough to fire, some short bounces
          if ($urandom_range(0, 5) == 0) run_left[i] = $urandom_range(1, 2);
          else run_left[i] = $urandom_range(2, 2 * int'(len) + 6);
        end
        run_left[i]--;
      end
      raw = target;
      if ($urandom_range(0, 11) == 0) raw[$urandom_range(0, NUM_SW - 1)] ^= 1'b1;
      send_tick(raw);
    end
  endtask

  initial begin
    sample_q  = '0;
    settled_q = '0;
    held_mark = '0;
    led_q     = 1'b0;
    press_len = LONG_PRESS_RESET;
    for (int i = 0; i < NUM_SW; i++) hold_cnt[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_length();
    test_single_tick_length();
    test_led_toggle();
    test_zero_length();
    test_max_length();
    test_random_presses(TICK_W'(1), 300);
    test_random_presses(TICK_W'(3), 300);
    test_random_presses(TICK_W'(6), 300);
    test_random_presses(TICK_W'($urandom_range(2, 12)), 300);
    quiet = 1'b1;
    test_random_presses(TICK_W'($urandom_range(1, 20)), 300);
    wait_all_ticks();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule

[switch_debounce_long_press_core.f]
sv/sdlp_pkg.sv
sv/sdlp_lane.sv
sv/switch_debounce_long_press_core.sv
tb/tb_switch_debounce_long_press_core.sv
